FILE: rtl/dnb_pkg.sv
// ----------------------------------------------------------------------------
// dnb_pkg
// Shared types and constants for the damped needle ballistics block.
// ----------------------------------------------------------------------------
package dnb_pkg;

  localparam int DEF_FRAC_BITS = 16;

  localparam int POS_W    = 32;
  localparam int VEL_W    = 40;
  localparam int ACCEL_W  = 45;
  localparam int ERR_W    = 33;
  localparam int MUL_A_W  = 33;
  localparam int US_W     = 16;
  localparam int ELAPSED_W = 20;

  localparam int SPRING_K    = 90;
  localparam int DAMP_C      = 11;
  localparam int POS_ERR_DIV = 2000;
  localparam int VEL_ERR_DIV = 200;

  localparam int DEFAULT_US = 16000;
  localparam int MAX_US     = 50000;
  localparam int US_PER_S   = 1000000;

  localparam int SCALE_HIGH_UNITS = 300;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MUL_E,
    ST_MUL_VL,
    ST_MUL_VH,
    ST_MUL_AL,
    ST_MUL_AH,
    ST_VEL_UPD,
    ST_MUL_PL,
    ST_MUL_PH,
    ST_POS_UPD,
    ST_DONE
  } dnb_state_e;

  typedef enum logic {
    OP_VALUE = 1'b0,
    OP_TICK  = 1'b1
  } dnb_op_e;

  typedef enum logic {
    CFG_SCALE_LOW  = 1'b0,
    CFG_SCALE_HIGH = 1'b1
  } dnb_cfg_e;

  typedef struct packed {
    logic            start;
    logic [US_W-1:0] us;
  } dnb_div_req_t;

endpackage

FILE: rtl/damped_needle_ballistics.sv
// ----------------------------------------------------------------------------
// damped_needle_ballistics
// Meter needle following a target reading through a mass-spring-damper.
// ----------------------------------------------------------------------------
// One result item per input item. A new reading, or a tick while the needle
// rests, goes from accept straight to loading the output register. A tick
// while the needle moves takes these steps in order: latch the error and
// span, take the registered reciprocal-multiply time step, make nine passes
// through the single 33 x N multiply-accumulate unit for the spring/damper
// force, the velocity and position updates and the settle test, and load the
// output register once it is free. Input tready is high only while the
// sequencer is idle, so no new item is taken before the last is finished;
// a finished item waits in the output register.
module damped_needle_ballistics import dnb_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // [31:0] value, [51:32] elapsed_us
  input  logic        s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [31:0] needle_position, [32] reading_seen,
                                      // [33] in_motion
);

  localparam int DT_W    = FRAC_BITS - 3;
  localparam int MUL_B_W = (DT_W + 1 > 12) ? DT_W + 1 : 12;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 42 + FRAC_BITS;
  localparam int SHR_W   = ACC_W - FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [ERR_W-1:0] ONE  = ERR_W'(1) << FRAC_BITS;

  dnb_state_e state_q, state_d;

  logic signed [POS_W-1:0]   scale_low_q, scale_high_q;
  logic signed [POS_W-1:0]   target_q, target_d;
  logic signed [POS_W-1:0]   pos_q, pos_d;
  logic signed [VEL_W-1:0]   vel_q, vel_d;
  logic                      seen_q, seen_d;
  logic                      moving_q, moving_d;

  logic [US_W-1:0]           us_q, us_d;
  logic signed [ERR_W-1:0]   err_q, err_d;
  logic signed [ERR_W-1:0]   span_q, span_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [ACCEL_W-33:0] ahi_q, ahi_d;
  logic                      errok_q, errok_d;

  logic                      m_valid_q, m_valid_d;
  logic [39:0]               m_data_q, m_data_d;

  logic                      s_accept;
  logic signed [POS_W-1:0]   in_value;
  logic [ELAPSED_W-1:0]      in_elapsed;
  logic [US_W-1:0]           us_eff;

  dnb_div_req_t              div_req;
  logic [DT_W-1:0]           dt;
  logic                      div_done;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [ACC_W-1:0]   prod_ext, prod_sh, acc_base, acc_sum;
  logic                      use_sh;
  logic signed [ACC_W-1:0]   vel_init, pos_init;
  logic signed [SHR_W-1:0]   shr;
  logic signed [VEL_W-1:0]   vel_sat;
  logic signed [POS_W-1:0]   pos_sat;
  logic signed [MUL_P_W-1:0] span_p;
  logic                      in_band;
  logic                      vel_fits;
  logic signed [ERR_W-1:0]   span_raw;

  assign s_accept   = s_axis_tvalid && s_axis_tready;
  assign in_value   = signed'(s_axis_tdata[31:0]);
  assign in_elapsed = s_axis_tdata[51:32];

  always_comb begin
    if (in_elapsed == '0) begin
      us_eff = US_W'(DEFAULT_US);
    end else if (in_elapsed > ELAPSED_W'(MAX_US)) begin
      us_eff = US_W'(MAX_US);
    end else begin
      us_eff = in_elapsed[US_W-1:0];
    end
  end

  assign div_req.start = (state_q == ST_DIV_START);
  assign div_req.us    = us_q;

  dnb_dt_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dt_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .dt_o  (dt),
    .done_o(div_done)
  );

  // shared multiply-accumulate unit
  assign prod     = mul_a * mul_b;
  assign prod_ext = ACC_W'(prod);
  assign prod_sh  = {prod_ext[ACC_W-33:0], 32'd0};
  assign acc_sum  = acc_base + (use_sh ? prod_sh : prod_ext);

  // low FRAC_BITS bits are zero, so OR adds the rounding half
  assign vel_init = (ACC_W'(vel_q) <<< FRAC_BITS) | HALF;
  assign pos_init = (ACC_W'(pos_q) <<< FRAC_BITS) | HALF;

  assign shr = acc_q[ACC_W-1:FRAC_BITS];

  always_comb begin
    if (&shr[SHR_W-1:VEL_W-1] || ~|shr[SHR_W-1:VEL_W-1]) begin
      vel_sat = shr[VEL_W-1:0];
    end else if (shr[SHR_W-1]) begin
      vel_sat = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      vel_sat = {1'b0, {(VEL_W-1){1'b1}}};
    end
    if (&shr[SHR_W-1:POS_W-1] || ~|shr[SHR_W-1:POS_W-1]) begin
      pos_sat = shr[POS_W-1:0];
    end else if (shr[SHR_W-1]) begin
      pos_sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      pos_sat = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  assign span_p   = MUL_P_W'(span_q);
  assign in_band  = (prod < span_p) && (prod > -span_p);
  assign vel_fits = &vel_q[VEL_W-1:POS_W-1] || ~|vel_q[VEL_W-1:POS_W-1];
  assign span_raw = ERR_W'(scale_high_q) - ERR_W'(scale_low_q);

  always_comb begin
    state_d   = state_q;
    target_d  = target_q;
    pos_d     = pos_q;
    vel_d     = vel_q;
    seen_d    = seen_q;
    moving_d  = moving_q;
    us_d      = us_q;
    err_d     = err_q;
    span_d    = span_q;
    acc_d     = acc_q;
    ahi_d     = ahi_q;
    errok_d   = errok_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    mul_a     = err_q;
    mul_b     = MUL_B_W'(SPRING_K);
    acc_base  = acc_q;
    use_sh    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          if (s_axis_tuser == OP_VALUE) begin
            seen_d = 1'b1;
            if (in_value != target_q) begin
              target_d = in_value;
              moving_d = 1'b1;
            end
            state_d = ST_DONE;
          end else if (moving_q) begin
            us_d    = us_eff;
            state_d = ST_DIV_START;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DIV_START: begin
        err_d   = ERR_W'(target_q) - ERR_W'(pos_q);
        span_d  = (span_raw <= 0) ? signed'(ONE) : span_raw;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = ST_MUL_E;
        end
      end
      ST_MUL_E: begin
        mul_a    = err_q;
        mul_b    = MUL_B_W'(SPRING_K);
        acc_base = '0;
        acc_d    = acc_sum;
        state_d  = ST_MUL_VL;
      end
      ST_MUL_VL: begin
        mul_a   = signed'({1'b0, vel_q[31:0]});
        mul_b   = MUL_B_W'(-DAMP_C);
        acc_d   = acc_sum;
        state_d = ST_MUL_VH;
      end
      ST_MUL_VH: begin
        mul_a   = MUL_A_W'(signed'(vel_q[VEL_W-1:32]));
        mul_b   = MUL_B_W'(-DAMP_C);
        use_sh  = 1'b1;
        acc_d   = acc_sum;
        state_d = ST_MUL_AL;
      end
      ST_MUL_AL: begin
        mul_a    = signed'({1'b0, acc_q[31:0]});
        mul_b    = signed'(MUL_B_W'(dt));
        acc_base = vel_init;
        acc_d    = acc_sum;
        ahi_d    = acc_q[ACCEL_W-1:32];
        state_d  = ST_MUL_AH;
      end
      ST_MUL_AH: begin
        mul_a   = MUL_A_W'(ahi_q);
        mul_b   = signed'(MUL_B_W'(dt));
        use_sh  = 1'b1;
        acc_d   = acc_sum;
        state_d = ST_VEL_UPD;
      end
      ST_VEL_UPD: begin
        vel_d   = vel_sat;
        mul_a   = err_q;
        mul_b   = MUL_B_W'(POS_ERR_DIV);
        errok_d = in_band;
        state_d = ST_MUL_PL;
      end
      ST_MUL_PL: begin
        mul_a    = signed'({1'b0, vel_q[31:0]});
        mul_b    = signed'(MUL_B_W'(dt));
        acc_base = pos_init;
        acc_d    = acc_sum;
        state_d  = ST_MUL_PH;
      end
      ST_MUL_PH: begin
        mul_a   = MUL_A_W'(signed'(vel_q[VEL_W-1:32]));
        mul_b   = signed'(MUL_B_W'(dt));
        use_sh  = 1'b1;
        acc_d   = acc_sum;
        state_d = ST_POS_UPD;
      end
      ST_POS_UPD: begin
        mul_a = MUL_A_W'(signed'(vel_q[31:0]));
        mul_b = MUL_B_W'(VEL_ERR_DIV);
        if (errok_q && vel_fits && in_band) begin
          pos_d    = target_q;
          vel_d    = '0;
          moving_d = 1'b0;
        end else begin
          pos_d = pos_sat;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {6'd0, moving_q, seen_q, pos_q};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      scale_low_q  <= '0;
      scale_high_q <= POS_W'(SCALE_HIGH_UNITS) << FRAC_BITS;
      target_q     <= '0;
      pos_q        <= '0;
      vel_q        <= '0;
      seen_q       <= 1'b0;
      moving_q     <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      target_q  <= target_d;
      pos_q     <= pos_d;
      vel_q     <= vel_d;
      seen_q    <= seen_d;
      moving_q  <= moving_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        case (dnb_cfg_e'(cfg_idx_i))
          CFG_SCALE_LOW:  scale_low_q  <= signed'(cfg_wdata_i);
          CFG_SCALE_HIGH: scale_high_q <= signed'(cfg_wdata_i);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    us_q     <= us_d;
    err_q    <= err_d;
    span_q   <= span_d;
    acc_q    <= acc_d;
    ahi_q    <= ahi_d;
    errok_q  <= errok_d;
    m_data_q <= m_data_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_motion_needs_reading: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    moving_q |-> seen_q
  ) else $error("needle moving without a reading");

  a_motion_starts_on_value: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(moving_q) |-> $past(s_accept && (s_axis_tuser == OP_VALUE))
  ) else $error("motion started without a new reading");

  a_settle_snaps: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $fell(moving_q) |-> (pos_q == target_q) && (vel_q == '0)
  ) else $error("settled needle not snapped to target");

  a_div_done_in_wait: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_WAIT)
  ) else $error("time step ready outside of wait state");

endmodule

FILE: rtl/dnb_dt_div.sv
// ----------------------------------------------------------------------------
// dnb_dt_div
// Time step converter: dt = round(us * 2^F / 1e6) by a reciprocal multiply.
// ----------------------------------------------------------------------------
module dnb_dt_div import dnb_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dnb_div_req_t         req_i,
  output logic [FRAC_BITS-4:0] dt_o,
  output logic                 done_o
);

  localparam int QB       = FRAC_BITS - 3;
  localparam int RECIP_SH = 32;
  localparam int RECIP_W  = FRAC_BITS + RECIP_SH - 19;
  localparam int PROD_W   = US_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << (FRAC_BITS + RECIP_SH)) + 64'(US_PER_S / 2)) / 64'(US_PER_S);
  localparam logic [RECIP_W-1:0] RECIP_M    = RECIP_FULL[RECIP_W-1:0];
  localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(1) << (RECIP_SH - 1);

  logic              done_q, done_d;
  logic [QB-1:0]     dt_q, dt_d;
  logic [PROD_W-1:0] scaled;

  // 2^(F+32)/1e6 rounded; the error stays far below the distance of any
  // exact quotient to a rounding boundary for us up to 50000
  assign scaled = PROD_W'(req_i.us) * PROD_W'(RECIP_M) + ROUND_HALF;

  always_comb begin
    done_d = req_i.start;
    dt_d   = dt_q;
    if (req_i.start) begin
      dt_d = scaled[RECIP_SH +: QB];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q <= dt_d;
  end

  assign dt_o   = dt_q;
  assign done_o = done_q;

endmodule

FILE: dv/damped_needle_ballistics_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_needle_ballistics_tb
// Drives readings and animation ticks into the needle block under several
// scale settings and checks every result item against an in-bench
// spring/damper predictor, with random idling and backpressure on both sides.
// ----------------------------------------------------------------------------
module damped_needle_ballistics_tb;
  import dnb_pkg::*;

  typedef struct packed {
    logic        in_motion;
    logic        reading_seen;
    logic [31:0] needle_position;
  } needle_readout_t;

  class needle_scoreboard;
    longint          lo_end, hi_end;
    longint          target, pos, vel;
    bit              seen, moving;
    needle_readout_t expected_readouts[$];
    int              errors;

    function new();
      lo_end  = 0;
      hi_end  = longint'(SCALE_HIGH_UNITS) << DEF_FRAC_BITS;
      target  = 0;
      pos     = 0;
      vel     = 0;
      seen    = 0;
      moving  = 0;
      errors  = 0;
    endfunction

    function void write_reg(dnb_cfg_e idx, logic [31:0] data);
      if (idx == CFG_SCALE_LOW) begin
        lo_end = longint'($signed(data));
      end else begin
        hi_end = longint'($signed(data));
      end
    endfunction

    function longint clamp(longint x, int bits);
      longint top, bottom;
      top    = (longint'(1) << (bits - 1)) - 1;
      bottom = -(longint'(1) << (bits - 1));
      return (x > top) ? top : ((x < bottom) ? bottom : x);
    endfunction

    function longint mag(longint x);
      return (x < 0) ? -x : x;
    endfunction

    // One semi-implicit Euler step; products round half up at FRAC_BITS.
    function void advance_needle(logic [19:0] us);
      longint u, dt, err, accel, span, half;
      half = longint'(1) << (DEF_FRAC_BITS - 1);
      u = (us == 0) ? longint'(DEFAULT_US) : longint'(us);
      if (u > MAX_US) u = MAX_US;
      dt    = ((u << DEF_FRAC_BITS) + US_PER_S / 2) / US_PER_S;
      err   = target - pos;
      accel = SPRING_K * err - DAMP_C * vel;
      vel   = clamp(vel + ((accel * dt + half) >>> DEF_FRAC_BITS), VEL_W);
      pos   = clamp(pos + ((vel * dt + half) >>> DEF_FRAC_BITS), POS_W);
      span  = hi_end - lo_end;
      if (span <= 0) span = longint'(1) << DEF_FRAC_BITS;
      if (mag(err) * POS_ERR_DIV < span && mag(vel) * VEL_ERR_DIV < span) begin
        pos    = target;
        vel    = 0;
        moving = 0;
      end
    endfunction

    function void note_item(dnb_op_e op, logic [31:0] reading, logic [19:0] us);
      needle_readout_t want;
      if (op == OP_VALUE) begin
        seen = 1;
        if (longint'($signed(reading)) != target) begin
          target = longint'($signed(reading));
          moving = 1;
        end
      end else if (moving) begin
        advance_needle(us);
      end
      want.needle_position = pos[31:0];
      want.reading_seen    = seen;
      want.in_motion       = moving;
      expected_readouts.push_back(want);
    endfunction

    function void check_result(logic [39:0] data);
      needle_readout_t got, want;
      got = data[33:0];
      if (expected_readouts.size() == 0) begin
        $display("%0t: unexpected result item %h", $time, data);
        errors++;
        return;
      end
      want = expected_readouts.pop_front();
      if (got.needle_position !== want.needle_position) begin
        $display("%0t: needle_position expected %0d got %0d", $time,
                 $signed(want.needle_position), $signed(got.needle_position));
        errors++;
      end
      if (got.reading_seen !== want.reading_seen) begin
        $display("%0t: reading_seen expected %0b got %0b", $time,
                 want.reading_seen, got.reading_seen);
        errors++;
      end
      if (got.in_motion !== want.in_motion) begin
        $display("%0t: in_motion expected %0b got %0b", $time,
                 want.in_motion, got.in_motion);
        errors++;
      end
    endfunction

    function int pending();
      return expected_readouts.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic [31:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  needle_scoreboard sb = new();

  bit quiet;
  int hold_reqs;
  int hold_seen;
  int hold_left;
  int cur_low  = 0;
  int cur_high = SCALE_HIGH_UNITS << DEF_FRAC_BITS;
  logic [31:0] last_reading;

  damped_needle_ballistics dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result side: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 34);
    end
  end

  task automatic send_item(input dnb_op_e op, input logic [31:0] reading,
                           input logic [19:0] us);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, us, reading};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(op, reading, us);
    if (op == OP_VALUE) last_reading = reading;
    if (!quiet && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(40, 8)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(3, 1)) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_scale(input int low_end, input int high_end);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SCALE_LOW;
    cfg_wdata_i <= low_end;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SCALE_HIGH;
    cfg_wdata_i <= high_end;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    sb.write_reg(CFG_SCALE_LOW, low_end);
    sb.write_reg(CFG_SCALE_HIGH, high_end);
    cur_low  = low_end;
    cur_high = high_end;
  endtask

  function automatic logic [19:0] pick_elapsed();
    case ($urandom_range(9))
      0:       return 20'd0;
      1:       return 20'(MAX_US);
      2:       return 20'($urandom_range(1000000, MAX_US + 1));
      3:       return 20'($urandom_range(1000));
      default: return 20'($urandom_range(MAX_US, 1));
    endcase
  endfunction

  function automatic logic [31:0] pick_reading();
    longint span_l, off;
    case ($urandom_range(9))
      0: return $urandom();
      1: begin
        case ($urandom_range(2))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          default: return 32'h0;
        endcase
      end
      2: return last_reading;
      default: begin
        if (cur_high > cur_low) begin
          span_l = longint'(cur_high) - longint'(cur_low);
          off = longint'({$urandom(), $urandom()} & 64'h7fff_ffff_ffff_ffff) % (span_l + 1);
          return 32'(longint'(cur_low) + off);
        end
        return 32'(int'($urandom_range(100 << DEF_FRAC_BITS)) - (50 << DEF_FRAC_BITS));
      end
    endcase
  endfunction

  initial begin
    int n;
    int low_end, high_end;
    last_reading = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset scale of 0..300
    send_item(OP_TICK,  32'h0, 20'd12345);
    send_item(OP_VALUE, 32'h0, 20'd0);
    send_item(OP_TICK,  32'h0, 20'd0);
    send_item(OP_VALUE, 32'd19660800, 20'hfffff);
    send_item(OP_TICK,  32'h0, 20'd0);
    send_item(OP_TICK,  32'h0, 20'(MAX_US));
    send_item(OP_TICK,  32'h0, 20'd1000000);
    send_item(OP_TICK,  32'h0, 20'(MAX_US + 1));
    send_item(OP_TICK,  32'h0, 20'd1);
    send_item(OP_TICK,  32'hffff_ffff, 20'(DEFAULT_US));
    send_item(OP_VALUE, 32'd19660800, 20'd0);
    send_item(OP_VALUE, 32'h7fff_ffff, 20'd0);
    repeat (4) send_item(OP_TICK, 32'h0, 20'(MAX_US));
    send_item(OP_VALUE, 32'h8000_0000, 20'd0);
    repeat (4) send_item(OP_TICK, 32'h0, 20'd1000000);
    send_item(OP_VALUE, 32'd150 << DEF_FRAC_BITS, 20'd0);
    repeat (4) send_item(OP_TICK, 32'h0, 20'd0);
    wait_all_results();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin low_end = 0; high_end = SCALE_HIGH_UNITS << DEF_FRAC_BITS; end
        1: begin low_end = 32'h8000_0000; high_end = 32'h7fff_ffff; end
        2: begin low_end = 32'h7fff_ffff; high_end = 32'h8000_0000; end
        3: begin low_end = 5 << DEF_FRAC_BITS; high_end = 5 << DEF_FRAC_BITS; end
        4: begin low_end = -(100 << DEF_FRAC_BITS); high_end = 100 << DEF_FRAC_BITS; end
        default: begin low_end = $urandom(); high_end = $urandom(); end
      endcase
      write_scale(low_end, high_end);
      quiet = (phase == 4);
      n = 0;
      while (n < 205) begin
        if (n >= 100 && (phase == 1 || phase == 3) && hold_reqs == hold_seen
            && hold_left == 0 && phase * 2 > hold_reqs) hold_reqs++;
        if (phase == 2 && n >= 100 && n < 102) wait_all_results();
        send_item(OP_VALUE, pick_reading(), pick_elapsed());
        n++;
        repeat ($urandom_range(40, 2)) begin
          send_item(OP_TICK, $urandom(), pick_elapsed());
          n++;
        end
      end
      wait_all_results();
    end
    quiet = 0;

    if (sb.errors == 0) begin
      $display("** damped_needle_ballistics: PASSED **");
    end else begin
      $display("** damped_needle_ballistics: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** damped_needle_ballistics: FAILED **");
    $finish;
  end

endmodule
